// ===== hw/rtl/hsl2rgb_pkg.sv =====
// ----------------------------------------------------------------------------
// hsl2rgb_pkg: shared constants and types of the HSL to RGB converter
// Default input precision, channel width and the hue sextant codes.
// ----------------------------------------------------------------------------
package hsl2rgb_pkg;

  // Default bits of hue, saturation and lightness
  localparam int unsigned IN_BITS_DEF = 16;

  // Bits of one output color channel
  localparam int unsigned CH_BITS = 8;

  // Hue sextant: which sixth of the color wheel a hue falls in
  typedef enum logic [2:0] {
    SEXT_RED_YEL = 3'd0,
    SEXT_YEL_GRN = 3'd1,
    SEXT_GRN_CYN = 3'd2,
    SEXT_CYN_BLU = 3'd3,
    SEXT_BLU_MAG = 3'd4,
    SEXT_MAG_RED = 3'd5
  } sextant_e;

endpackage

// ===== hw/rtl/hsl2rgb_if.sv =====
// ----------------------------------------------------------------------------
// hsl2rgb_if: request channels of the HSL to RGB converter
// Valid/ready channels for HSL pixels in and 8-bit RGB pixels out.
// ----------------------------------------------------------------------------
interface hsl2rgb_hsl_if #(
  parameter int unsigned Bits = hsl2rgb_pkg::IN_BITS_DEF
);
  logic            valid;
  logic            ready;
  logic [Bits-1:0] hue;
  logic [Bits-1:0] saturation;
  logic [Bits-1:0] lightness;

  modport source (output valid, output hue, output saturation, output lightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input lightness,
                  output ready);
endinterface

interface hsl2rgb_rgb_if;
  logic                             valid;
  logic                             ready;
  logic [hsl2rgb_pkg::CH_BITS-1:0] red;
  logic [hsl2rgb_pkg::CH_BITS-1:0] green;
  logic [hsl2rgb_pkg::CH_BITS-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ===== hw/rtl/hsl2rgb_chroma.sv =====
// ----------------------------------------------------------------------------
// hsl2rgb_chroma: chroma top, bottom and span of one pixel
// Three stages: products, chroma top v, then bottom m and span v - m.
// All values are exact integers in units of 1/F^2, F = 2^IN_BITS - 1.
// ----------------------------------------------------------------------------
module hsl2rgb_chroma #(
  parameter int unsigned IN_BITS = hsl2rgb_pkg::IN_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    adv_i,
  input  logic                    valid_i,
  input  logic [IN_BITS-1:0]      hue_i,
  input  logic [IN_BITS-1:0]      saturation_i,
  input  logic [IN_BITS-1:0]      lightness_i,
  output logic                    valid_o,
  output logic [2*IN_BITS-1:0]    top_o,
  output logic [2*IN_BITS-1:0]    bottom_o,
  output logic [2*IN_BITS-1:0]    span_o,
  output hsl2rgb_pkg::sextant_e   sext_o,
  output logic [IN_BITS-1:0]      fract_o
);

  localparam int unsigned W2 = 2 * IN_BITS;

  // Stage 1 signals
  logic                  s1_valid_q;
  logic [W2-1:0]         ls_d, ls_q;
  logic [W2-1:0]         lf_d, lf_q;
  logic [W2-1:0]         sf_d, sf_q;
  logic                  half_d, half_q;
  logic [IN_BITS+2:0]    hue6;
  hsl2rgb_pkg::sextant_e sext1_d, sext1_q;
  logic [IN_BITS-1:0]    fract1_q;

  // Stage 2 signals
  logic                  s2_valid_q;
  logic [W2:0]           top_sum;
  logic [W2-1:0]         top_d, top_q;
  logic [W2-1:0]         lf2_q;
  hsl2rgb_pkg::sextant_e sext2_q;
  logic [IN_BITS-1:0]    fract2_q;

  // Stage 3 signals
  logic                  s3_valid_q;
  logic [W2:0]           bottom_sum;
  logic [W2-1:0]         half_span;
  logic [W2-1:0]         bottom_d, bottom_q;
  logic [W2-1:0]         span_d, span_q;
  logic [W2-1:0]         top3_q;
  hsl2rgb_pkg::sextant_e sext3_q;
  logic [IN_BITS-1:0]    fract3_q;

  // Form L*S, L*F and S*F (times F as shift and subtract), split hue by six
  always_comb begin
    ls_d    = W2'(lightness_i) * W2'(saturation_i);
    lf_d    = {lightness_i, {IN_BITS{1'b0}}} - {{IN_BITS{1'b0}}, lightness_i};
    sf_d    = {saturation_i, {IN_BITS{1'b0}}} - {{IN_BITS{1'b0}}, saturation_i};
    half_d  = ~lightness_i[IN_BITS-1];
    hue6    = {1'b0, hue_i, 2'b00} + {2'b00, hue_i, 1'b0};
    sext1_d = hsl2rgb_pkg::sextant_e'(hue6[IN_BITS+2:IN_BITS]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv_i) begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ls_q     <= ls_d;
      lf_q     <= lf_d;
      sf_q     <= sf_d;
      half_q   <= half_d;
      sext1_q  <= sext1_d;
      fract1_q <= hue6[IN_BITS-1:0];
    end
  end

  // Chroma top: L*(F+S) up to one half lightness, else L*F + S*F - L*S
  always_comb begin
    if (half_q) begin
      top_sum = {1'b0, lf_q} + {1'b0, ls_q};
    end else begin
      top_sum = {1'b0, lf_q} + {1'b0, sf_q} - {1'b0, ls_q};
    end
    top_d = top_sum[W2-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv_i) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      top_q    <= top_d;
      lf2_q    <= lf_q;
      sext2_q  <= sext1_q;
      fract2_q <= fract1_q;
    end
  end

  // Bottom m = 2*L*F - v and span v - m = 2*(v - L*F); v never falls below L*F
  always_comb begin
    bottom_sum = {lf2_q, 1'b0} - {1'b0, top_q};
    bottom_d   = bottom_sum[W2-1:0];
    half_span  = top_q - lf2_q;
    span_d     = {half_span[W2-2:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (adv_i) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      bottom_q <= bottom_d;
      span_q   <= span_d;
      top3_q   <= top_q;
      sext3_q  <= sext2_q;
      fract3_q <= fract2_q;
    end
  end

  assign valid_o  = s3_valid_q;
  assign top_o    = top3_q;
  assign bottom_o = bottom_q;
  assign span_o   = span_q;
  assign sext_o   = sext3_q;
  assign fract_o  = fract3_q;

endmodule

// ===== hw/rtl/hsl2rgb_mix.sv =====
// ----------------------------------------------------------------------------
// hsl2rgb_mix: rising and falling mids and sextant selection
// Three stages: split span product, offset sum, mids and channel select.
// ----------------------------------------------------------------------------
module hsl2rgb_mix #(
  parameter int unsigned IN_BITS = hsl2rgb_pkg::IN_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  logic                  valid_i,
  input  logic [2*IN_BITS-1:0]  top_i,
  input  logic [2*IN_BITS-1:0]  bottom_i,
  input  logic [2*IN_BITS-1:0]  span_i,
  input  hsl2rgb_pkg::sextant_e sext_i,
  input  logic [IN_BITS-1:0]    fract_i,
  output logic                  valid_o,
  output logic [2*IN_BITS-1:0]  chan_o [3]
);

  localparam int unsigned W2 = 2 * IN_BITS;

  // Stage 4 signals
  logic                  s4_valid_q;
  logic [W2-1:0]         prod_hi_d, prod_hi_q;
  logic [W2-1:0]         prod_lo_d, prod_lo_q;
  logic [W2-1:0]         top4_q, bottom4_q;
  hsl2rgb_pkg::sextant_e sext4_q;

  // Stage 5 signals
  logic                  s5_valid_q;
  logic [W2-1:0]         offset_d, offset_q;
  logic [W2-1:0]         top5_q, bottom5_q;
  hsl2rgb_pkg::sextant_e sext5_q;

  // Stage 6 signals
  logic                  s6_valid_q;
  logic [W2-1:0]         rise, fall;
  logic [W2-1:0]         chan_d [3];
  logic [W2-1:0]         chan_q [3];

  // Split span into halves so each product stays IN_BITS by IN_BITS
  always_comb begin
    prod_hi_d = W2'(span_i[W2-1:IN_BITS]) * W2'(fract_i);
    prod_lo_d = W2'(span_i[IN_BITS-1:0]) * W2'(fract_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else if (adv_i) begin
      s4_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_hi_q <= prod_hi_d;
      prod_lo_q <= prod_lo_d;
      top4_q    <= top_i;
      bottom4_q <= bottom_i;
      sext4_q   <= sext_i;
    end
  end

  // Offset = floor(span * fract / 2^IN_BITS); the high half product is exact
  assign offset_d = prod_hi_q + W2'(prod_lo_q[W2-1:IN_BITS]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_valid_q <= 1'b0;
    end else if (adv_i) begin
      s5_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      offset_q  <= offset_d;
      top5_q    <= top4_q;
      bottom5_q <= bottom4_q;
      sext5_q   <= sext4_q;
    end
  end

  // Form mids and route top, bottom and mids to channels by sextant.
  // Zero lightness gives zero top and bottom, so every channel is black.
  always_comb begin
    rise = bottom5_q + offset_q;
    fall = top5_q - offset_q;
    case (sext5_q)
      hsl2rgb_pkg::SEXT_RED_YEL: begin
        chan_d[0] = top5_q;    chan_d[1] = rise;      chan_d[2] = bottom5_q;
      end
      hsl2rgb_pkg::SEXT_YEL_GRN: begin
        chan_d[0] = fall;      chan_d[1] = top5_q;    chan_d[2] = bottom5_q;
      end
      hsl2rgb_pkg::SEXT_GRN_CYN: begin
        chan_d[0] = bottom5_q; chan_d[1] = top5_q;    chan_d[2] = rise;
      end
      hsl2rgb_pkg::SEXT_CYN_BLU: begin
        chan_d[0] = bottom5_q; chan_d[1] = fall;      chan_d[2] = top5_q;
      end
      hsl2rgb_pkg::SEXT_BLU_MAG: begin
        chan_d[0] = rise;      chan_d[1] = bottom5_q; chan_d[2] = top5_q;
      end
      default: begin
        chan_d[0] = top5_q;    chan_d[1] = bottom5_q; chan_d[2] = fall;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_valid_q <= 1'b0;
    end else if (adv_i) begin
      s6_valid_q <= s5_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int c = 0; c < 3; c++) begin
        chan_q[c] <= chan_d[c];
      end
    end
  end

  assign valid_o = s6_valid_q;
  assign chan_o  = chan_q;

endmodule

// ===== hw/rtl/hsl2rgb_scale.sv =====
// ----------------------------------------------------------------------------
// hsl2rgb_scale: channel to byte scaler
// Computes floor(c * 255 / F^2) for three lanes in four stages: scale by 255,
// estimate the quotient with a reciprocal of F^2, form the remainder, then
// raise the estimate by one where the remainder still holds a full F^2.
// ----------------------------------------------------------------------------
module hsl2rgb_scale #(
  parameter int unsigned IN_BITS = hsl2rgb_pkg::IN_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             adv_i,
  input  logic                             valid_i,
  input  logic [2*IN_BITS-1:0]             chan_i [3],
  output logic                             valid_o,
  output logic [hsl2rgb_pkg::CH_BITS-1:0]  byte_o [3]
);

  localparam int unsigned CB    = hsl2rgb_pkg::CH_BITS;
  localparam int unsigned W2    = 2 * IN_BITS;
  localparam int unsigned RW    = W2 + CB;
  localparam logic [RW-1:0] FullScale = RW'({IN_BITS{1'b1}});
  localparam logic [RW-1:0] Divisor   = FullScale * FullScale;

  // Stage 7 signals
  logic          s7_valid_q;
  logic [RW-1:0] scaled_q [3];

  // Stage 8 signals
  logic          s8_valid_q;
  logic [RW-1:0] est_sum [3];
  logic [RW-1:0] scaled8_q [3];
  logic [CB-1:0] est_q [3];

  // Stage 9 signals
  logic          s9_valid_q;
  logic [RW-1:0] rem_d [3];
  logic [RW-1:0] rem_q [3];
  logic [CB-1:0] est9_q [3];

  // Stage 10 signals
  logic          s10_valid_q;
  logic [CB-1:0] byte_d [3];
  logic [CB-1:0] byte_q [3];

  // Load 255*c as (c << 8) - c
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_valid_q <= 1'b0;
    end else if (adv_i) begin
      s7_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int c = 0; c < 3; c++) begin
        scaled_q[c] <= {chan_i[c], {CB{1'b0}}} - {{CB{1'b0}}, chan_i[c]};
      end
    end
  end

  // Estimate x / F^2 as (x + x * 2^-(IN_BITS-1)) / 2^(2*IN_BITS); never above
  // the true quotient and at most one below it
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      est_sum[c] = scaled_q[c] + (scaled_q[c] >> (IN_BITS - 1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s8_valid_q <= 1'b0;
    end else if (adv_i) begin
      s8_valid_q <= s7_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int c = 0; c < 3; c++) begin
        est_q[c]     <= est_sum[c][RW-1:W2];
        scaled8_q[c] <= scaled_q[c];
      end
    end
  end

  // Remainder left after the estimate, below two times F^2
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rem_d[c] = scaled8_q[c] - RW'(est_q[c]) * Divisor;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s9_valid_q <= 1'b0;
    end else if (adv_i) begin
      s9_valid_q <= s8_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int c = 0; c < 3; c++) begin
        rem_q[c]  <= rem_d[c];
        est9_q[c] <= est_q[c];
      end
    end
  end

  // Bump the estimate where one more F^2 fits in the remainder
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      byte_d[c] = est9_q[c] + CB'(rem_q[c] >= Divisor);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s10_valid_q <= 1'b0;
    end else if (adv_i) begin
      s10_valid_q <= s9_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int c = 0; c < 3; c++) begin
        byte_q[c] <= byte_d[c];
      end
    end
  end

  assign valid_o = s10_valid_q;
  assign byte_o  = byte_q;

endmodule

// ===== hw/rtl/hsl_to_rgb_converter.sv =====
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter: HSL pixel to 8-bit RGB pixel
// Stateless color conversion in exact fixed point over a 10-stage pipeline.
//
//   channel | dir | fields                        | format
//   --------+-----+-------------------------------+-------------------------
//   hsl_i   | in  | hue, saturation, lightness    | IN_BITS each, unsigned
//   rgb_o   | out | red, green, blue              | 8 bits each, unsigned
//
// One pixel enters per clock unless a held result stalls; the pipeline has
// three chroma stages, three mix stages and four scaler stages (scale by
// 255, reciprocal estimate of the divide by F^2, remainder, correction).
// Reset clears only the stage valid bits. A held rgb_o result freezes every
// stage at once, bubbles included, and drops hsl_i.ready until it is taken.
// ----------------------------------------------------------------------------
module hsl_to_rgb_converter #(
  parameter int unsigned IN_BITS = hsl2rgb_pkg::IN_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  hsl2rgb_hsl_if.sink   hsl_i,
  hsl2rgb_rgb_if.source rgb_o
);

  localparam int unsigned W2 = 2 * IN_BITS;

  logic                                   adv;
  logic                                   chroma_valid;
  logic [W2-1:0]                          top, bottom, span;
  hsl2rgb_pkg::sextant_e                  sext;
  logic [IN_BITS-1:0]                     fract;
  logic                                   mix_valid;
  logic [W2-1:0]                          chan [3];
  logic                                   out_valid;
  logic [hsl2rgb_pkg::CH_BITS-1:0]        out_byte [3];

  // Advance the whole pipeline unless a finished result is held
  assign adv         = ~out_valid | rgb_o.ready;
  assign hsl_i.ready = adv;

  hsl2rgb_chroma #(
    .IN_BITS (IN_BITS)
  ) u_chroma (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .valid_i      (hsl_i.valid),
    .hue_i        (hsl_i.hue),
    .saturation_i (hsl_i.saturation),
    .lightness_i  (hsl_i.lightness),
    .valid_o      (chroma_valid),
    .top_o        (top),
    .bottom_o     (bottom),
    .span_o       (span),
    .sext_o       (sext),
    .fract_o      (fract)
  );

  hsl2rgb_mix #(
    .IN_BITS (IN_BITS)
  ) u_mix (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .valid_i  (chroma_valid),
    .top_i    (top),
    .bottom_i (bottom),
    .span_i   (span),
    .sext_i   (sext),
    .fract_i  (fract),
    .valid_o  (mix_valid),
    .chan_o   (chan)
  );

  hsl2rgb_scale #(
    .IN_BITS (IN_BITS)
  ) u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (mix_valid),
    .chan_i  (chan),
    .valid_o (out_valid),
    .byte_o  (out_byte)
  );

  // Drive the result request from the last scaler stage
  assign rgb_o.valid = out_valid;
  assign rgb_o.red   = out_byte[0];
  assign rgb_o.green = out_byte[1];
  assign rgb_o.blue  = out_byte[2];

endmodule

// ===== test/rgb_pixel_checker.sv =====
// ----------------------------------------------------------------------------
// rgb_pixel_checker: expected-pixel tracker for the HSL to RGB converter
// Watches both request channels, computes the RGB pixel each accepted HSL
// request should produce and compares every output request field by field.
// ----------------------------------------------------------------------------
module rgb_pixel_checker
  import hsl2rgb_pkg::*;
#(
  parameter int unsigned Bits = IN_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  hsl2rgb_hsl_if        hsl_mon,
  hsl2rgb_rgb_if        rgb_mon,
  output int            errors_o,
  output int            pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CH_BITS-1:0] red;
    logic [CH_BITS-1:0] green;
    logic [CH_BITS-1:0] blue;
  } rgb_pixel_t;

  rgb_pixel_t rgb_expected_q[$];
  int         pushed_cnt;
  int         popped_cnt;
  int         error_cnt;

  assign errors_o  = error_cnt;
  assign pending_o = pushed_cnt - popped_cnt;

  // Scale a channel held in units of 1/F^2 to a byte, floor and clamp
  function automatic logic [CH_BITS-1:0] to_channel(input bit [63:0] c, input bit [63:0] unit);
    bit [63:0] q;
    q = (c * 64'd255) / unit;
    if (q > 64'd255) q = 64'd255;
    return q[CH_BITS-1:0];
  endfunction

  // Exact fixed-point HSL to RGB conversion
  function automatic rgb_pixel_t predict_rgb(input logic [Bits-1:0] h, input logic [Bits-1:0] s,
                                             input logic [Bits-1:0] l);
    bit [63:0]  f;
    bit [63:0]  unit;
    bit [63:0]  hh;
    bit [63:0]  ss;
    bit [63:0]  ll;
    bit [63:0]  v;
    bit [63:0]  m;
    bit [63:0]  h6;
    bit [63:0]  off;
    bit [63:0]  rise;
    bit [63:0]  fall;
    bit [63:0]  r;
    bit [63:0]  g;
    bit [63:0]  b;
    bit [127:0] prod;
    sextant_e   sext;
    rgb_pixel_t px;
    f    = (64'd1 << Bits) - 64'd1;
    unit = f * f;
    hh   = 64'(h);
    ss   = 64'(s);
    ll   = 64'(l);
    // chroma top depends on which half the lightness lies in
    if (64'd2 * ll <= f) begin
      v = ll * (f + ss);
    end else begin
      v = ll * f + ss * f - ll * ss;
    end
    r = ll * f;
    g = r;
    b = r;
    // zero chroma top keeps the gray value
    if (v != 64'd0) begin
      h6   = hh * 64'd6;
      sext = sextant_e'(3'(h6 >> Bits));
      m    = 64'd2 * ll * f - v;
      prod = 128'(v - m) * 128'(h6 & f);
      off  = 64'(prod >> Bits);
      rise = m + off;
      fall = v - off;
      case (sext)
        SEXT_RED_YEL: begin r = v;    g = rise; b = m;    end
        SEXT_YEL_GRN: begin r = fall; g = v;    b = m;    end
        SEXT_GRN_CYN: begin r = m;    g = v;    b = rise; end
        SEXT_CYN_BLU: begin r = m;    g = fall; b = v;    end
        SEXT_BLU_MAG: begin r = rise; g = m;    b = v;    end
        default:      begin r = v;    g = m;    b = fall; end
      endcase
    end
    px.red   = to_channel(r, unit);
    px.green = to_channel(g, unit);
    px.blue  = to_channel(b, unit);
    return px;
  endfunction

  // Record expectations on input requests, compare on output requests
  always @(posedge clk_i or negedge rst_ni) begin
    rgb_pixel_t want;
    if (!rst_ni) begin
      pushed_cnt <= 0;
      popped_cnt <= 0;
      error_cnt  <= 0;
      rgb_expected_q.delete();
    end else begin
      if (hsl_mon.valid && hsl_mon.ready) begin
        rgb_expected_q.push_back(predict_rgb(hsl_mon.hue, hsl_mon.saturation,
                                             hsl_mon.lightness));
        pushed_cnt <= pushed_cnt + 1;
      end
      if (rgb_mon.valid && rgb_mon.ready) begin
        if (rgb_expected_q.size() == 0) begin
          $display("%0t: unexpected pixel r=%0d g=%0d b=%0d", $time,
                   rgb_mon.red, rgb_mon.green, rgb_mon.blue);
          error_cnt <= error_cnt + 1;
        end else begin
          want = rgb_expected_q.pop_front();
          popped_cnt <= popped_cnt + 1;
          if (want.red !== rgb_mon.red || want.green !== rgb_mon.green ||
              want.blue !== rgb_mon.blue) begin
            error_cnt <= error_cnt + 1;
          end
          if (want.red !== rgb_mon.red) begin
            $display("%0t: red expected %0d actual %0d", $time, want.red, rgb_mon.red);
          end
          if (want.green !== rgb_mon.green) begin
            $display("%0t: green expected %0d actual %0d", $time, want.green, rgb_mon.green);
          end
          if (want.blue !== rgb_mon.blue) begin
            $display("%0t: blue expected %0d actual %0d", $time, want.blue, rgb_mon.blue);
          end
        end
      end
    end
  end

endmodule

// ===== test/hsl_to_rgb_converter_tb.sv =====
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter_tb: stimulus and verdict for the HSL to RGB converter
// Sends directed and random HSL pixels under several idle and stall mixes,
// including a long output hold-off, and reports the checker's outcome.
// ----------------------------------------------------------------------------
module hsl_to_rgb_converter_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hsl2rgb_pkg::*;

  localparam int unsigned Bits        = IN_BITS_DEF;
  localparam int          PhaseItems  = 300;
  localparam int          HoldCycles  = 200;
  localparam int          DrainCycles = 40;
  localparam int          CycleLimit  = 200000;

  logic clk_i = 1'b0;
  logic rst_ni;

  hsl2rgb_hsl_if #(.Bits(Bits)) hsl_ch ();
  hsl2rgb_rgb_if                rgb_ch ();

  int errors;
  int pending;
  int cycle_cnt = 0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_token     = 0;
  int hold_seen      = 0;
  int hold_left      = 0;

  // Hue values at which the sextant steps up
  int sext_start[6] = '{0, 10923, 21846, 32768, 43691, 54614};

  hsl_to_rgb_converter #(.IN_BITS(Bits)) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .hsl_i (hsl_ch),
    .rgb_o (rgb_ch)
  );

  rgb_pixel_checker #(.Bits(Bits)) i_checker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .hsl_mon  (hsl_ch),
    .rgb_mon  (rgb_ch),
    .errors_o (errors),
    .pending_o(pending)
  );

  always #5 clk_i = ~clk_i;

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Drive output ready: random stalls, or a long hold when requested
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      rgb_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_token != hold_seen) begin
      hold_seen    <= hold_token;
      hold_left    <= HoldCycles - 1;
      rgb_ch.ready <= 1'b0;
    end else begin
      rgb_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one pixel after random idle cycles, hold until accepted
  task automatic send_pixel(input logic [Bits-1:0] h, input logic [Bits-1:0] s,
                            input logic [Bits-1:0] l);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      hsl_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    hsl_ch.valid      <= 1'b1;
    hsl_ch.hue        <= h;
    hsl_ch.saturation <= s;
    hsl_ch.lightness  <= l;
    do @(posedge clk_i); while (!hsl_ch.ready);
  endtask

  // Random pixel, biased toward boundaries of lightness, saturation and hue
  task automatic send_random_pixel();
    logic [Bits-1:0] h;
    logic [Bits-1:0] s;
    logic [Bits-1:0] l;
    int              kind;
    h    = Bits'($urandom);
    s    = Bits'($urandom);
    l    = Bits'($urandom);
    kind = $urandom_range(9);
    case (kind)
      6: begin
        case ($urandom_range(3))
          0: l = '0;
          1: l = '1;
          2: l = Bits'(32767 + $urandom_range(1));
          default: l = Bits'($urandom_range(3));
        endcase
      end
      7: h = Bits'(sext_start[$urandom_range(5)] + $urandom_range(4) - 2);
      8: s = $urandom_range(1) ? '1 : '0;
      9: begin
        h = $urandom_range(1) ? '1 : '0;
        s = $urandom_range(1) ? '1 : '0;
        l = $urandom_range(1) ? '1 : '0;
      end
      default: ;
    endcase
    send_pixel(h, s, l);
  endtask

  initial begin
    hsl_ch.valid      <= 1'b0;
    hsl_ch.hue        <= '0;
    hsl_ch.saturation <= '0;
    hsl_ch.lightness  <= '0;
    rst_ni            <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, gray and black, lightness halves, sextant edges
    send_pixel('0, '0, '0);
    send_pixel('1, '1, '1);
    send_pixel('0, '1, '0);
    send_pixel('1, '0, '1);
    send_pixel('0, '0, Bits'(32767));
    send_pixel('0, '1, Bits'(32767));
    send_pixel('0, '1, Bits'(32768));
    send_pixel(Bits'(21846), '1, Bits'(1));
    send_pixel(Bits'(43690), '1, '1);
    send_pixel('1, '1, Bits'(32768));
    for (int k = 0; k < 6; k++) begin
      send_pixel(Bits'(sext_start[k]), '1, Bits'(32767));
      send_pixel(Bits'(sext_start[k] - 1), Bits'(40000), Bits'(20000));
    end
    send_pixel(Bits'(16'h5555), Bits'(16'haaaa), Bits'(16'h5555));
    send_pixel(Bits'(16'haaaa), Bits'(16'h5555), Bits'(16'haaaa));

    // No idling, with a long output hold-off while requests keep coming
    send_idle_pct  = 0;
    recv_stall_pct <= 0;
    hold_token     <= hold_token + 1;
    repeat (PhaseItems) send_random_pixel();

    // Sender mostly idle
    send_idle_pct = 80;
    repeat (PhaseItems) send_random_pixel();

    // Receiver mostly stalled
    send_idle_pct  = 0;
    recv_stall_pct <= 80;
    repeat (PhaseItems) send_random_pixel();

    // Both sides idle now and then
    send_idle_pct  = 14;
    recv_stall_pct <= 14;
    repeat (PhaseItems) send_random_pixel();

    // Drain the pipeline
    hsl_ch.valid   <= 1'b0;
    recv_stall_pct <= 0;
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
